/* rtl/core/mexp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the modular exponentiation block.
// No dependencies; imported by every module of the block.
package mexp_pkg;

	localparam int WIDTH     = 16;
	localparam int CNT_W     = $clog2(WIDTH);
	localparam int CFG_IDX_W = 2;

	typedef logic [WIDTH-1:0] val_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_EXPONENT = cfg_idx_t'(0);
	localparam cfg_idx_t REG_MODULUS  = cfg_idx_t'(1);

	// Request to the bit-serial modular multiplier.
	typedef struct packed {
		logic start;
		val_t a;
		val_t b;
	} mm_req_t;

	// Response from the bit-serial modular multiplier.
	typedef struct packed {
		logic busy;
		logic done;
		val_t res;
	} mm_rsp_t;

endpackage

/* rtl/core/mexp_mulmod.sv */
`timescale 1ns / 1ps
// Bit-serial modular multiplier: (a * b) mod m, one bit of b per cycle.
// Depends on mexp_pkg.
module mexp_mulmod (
	input  logic             clk,
	input  logic             arst_n,
	input  mexp_pkg::mm_req_t req,
	input  mexp_pkg::val_t   modulus,
	output mexp_pkg::mm_rsp_t rsp
);
	import mexp_pkg::*;

	val_t acc_q;
	val_t a_q;
	val_t b_q;
	cnt_t cnt_q;
	logic busy_q;
	logic done_q;

	logic [WIDTH+1:0] sum;
	logic [WIDTH+2:0] diff1;
	logic [WIDTH+2:0] diff2;
	val_t             step;

	// Double the accumulator and add a when the current bit of b is set.
	// The sum stays below 3m, so one of three candidates is the residue.
	always_comb begin
		sum   = {1'b0, acc_q, 1'b0} + {2'b00, (b_q[WIDTH-1] ? a_q : '0)};
		diff1 = {1'b0, sum} - {3'b000, modulus};
		diff2 = {1'b0, sum} - {2'b00, modulus, 1'b0};
		if (!diff2[WIDTH+2]) begin
			step = diff2[WIDTH-1:0];
		end else if (!diff1[WIDTH+2]) begin
			step = diff1[WIDTH-1:0];
		end else begin
			step = sum[WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - cnt_t'(1);
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cnt_t'(WIDTH - 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			acc_q <= step;
			b_q   <= {b_q[WIDTH-2:0], 1'b0};
		end else if (req.start) begin
			acc_q <= '0;
			a_q   <= req.a;
			b_q   <= req.b;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.res  = acc_q;

endmodule

/* rtl/core/modular_exponentiation.sv */
`timescale 1ns / 1ps
// Each modular multiplication runs in the bit-serial multiplier. A modulus below two
// skips the arithmetic and gives zero.
// The block works on one item at a time: a new input is taken only once the previous
// result has moved to the output register.
// Reset (arst_n, asynchronous, active low) clears the control state and loads
// exponent 0 and modulus all ones.
module modular_exponentiation (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  mexp_pkg::cfg_idx_t  cfg_index,
	input  mexp_pkg::val_t      cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  mexp_pkg::val_t      plain_value,
	output logic                out_valid,
	input  logic                out_stall,
	output mexp_pkg::val_t      power_result
);
	import mexp_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RED  = 3'd1;
	localparam logic [2:0] ST_SQR  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	// Configuration registers.
	val_t exponent_q;
	val_t modulus_q;

	// Per-item working state.
	logic [2:0] state_q;
	val_t       exp_q;
	val_t       base_q;
	val_t       acc_q;
	cnt_t       bit_q;

	// Output register: a finished result waits here while the next item starts.
	logic out_valid_q;
	val_t result_q;

	mm_req_t mm_req;
	mm_rsp_t mm_rsp;

	logic in_xfer;
	logic out_free;

	assign in_xfer  = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= '0;
			modulus_q  <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXPONENT: exponent_q <= cfg_data;
				REG_MODULUS:  modulus_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Multiplier request. The input is first reduced as 1 * plain_value mod m,
	// which the serial doubling handles correctly even for operands above m.
	// Each exponent bit, most significant first, squares the accumulator and,
	// when the bit is set, multiplies it by the reduced base.
	always_comb begin
		mm_req.start = 1'b0;
		mm_req.a     = acc_q;
		mm_req.b     = acc_q;
		unique case (state_q)
			ST_IDLE: begin
				mm_req.start = in_xfer && (modulus_q > val_t'(1));
				mm_req.a     = val_t'(1);
				mm_req.b     = plain_value;
			end
			ST_RED: begin
				mm_req.start = mm_rsp.done;
				mm_req.a     = val_t'(1);
				mm_req.b     = val_t'(1);
			end
			ST_SQR: begin
				mm_req.a = mm_rsp.res;
				if (exp_q[bit_q]) begin
					mm_req.start = mm_rsp.done;
					mm_req.b     = base_q;
				end else begin
					mm_req.start = mm_rsp.done && (bit_q != '0);
					mm_req.b     = mm_rsp.res;
				end
			end
			ST_MUL: begin
				mm_req.start = mm_rsp.done && (bit_q != '0);
				mm_req.a     = mm_rsp.res;
				mm_req.b     = mm_rsp.res;
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces the old one in the same cycle that the old
			// one is transferred out.
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= (modulus_q > val_t'(1)) ? ST_RED : ST_DONE;
					end
				end
				ST_RED: begin
					if (mm_rsp.done) begin
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					if (mm_rsp.done) begin
						if (exp_q[bit_q]) begin
							state_q <= ST_MUL;
						end else if (bit_q == '0) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_MUL: begin
					if (mm_rsp.done) begin
						state_q <= (bit_q == '0) ? ST_DONE : ST_SQR;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers carry payload only and need no reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					exp_q <= exponent_q;
					acc_q <= '0;
				end
			end
			ST_RED: begin
				if (mm_rsp.done) begin
					base_q <= mm_rsp.res;
					bit_q  <= cnt_t'(WIDTH - 1);
				end
			end
			ST_SQR: begin
				if (mm_rsp.done) begin
					acc_q <= mm_rsp.res;
					if (!exp_q[bit_q] && (bit_q != '0)) begin
						bit_q <= bit_q - cnt_t'(1);
					end
				end
			end
			ST_MUL: begin
				if (mm_rsp.done) begin
					acc_q <= mm_rsp.res;
					if (bit_q != '0) begin
						bit_q <= bit_q - cnt_t'(1);
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					result_q <= acc_q;
				end
			end
			default: ;
		endcase
	end

	mexp_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mm_req),
		.modulus (modulus_q),
		.rsp     (mm_rsp)
	);

	// Input transfers are taken only between items.
	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign power_result = result_q;

endmodule

/* rtl/core/mexp_check.sv */
`timescale 1ns / 1ps
// Port-level checker for the modular exponentiation block, bound to the top level.
// Depends on mexp_pkg and on modular_exponentiation.
module mexp_check (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input mexp_pkg::val_t     power_result
);
	import mexp_pkg::*;

	// A stalled result stays and holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(power_result))
		else $error("stalled result changed or vanished");

	// After an input transfer the block is busy with that item.
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after a transfer");

	// A new result only appears at the end of an item in work.
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared with no item in work");

endmodule

bind modular_exponentiation mexp_check u_check (.*);
